// ----- src/pts_pkg.sv -----
// shared types and constants of the priority thread scheduler
package pts_pkg;

  localparam int READY_DEPTH = 16;
  localparam int ID_BITS     = 6;
  localparam int PRIO_BITS   = 8;
  localparam int SLOT_BITS   = $clog2(READY_DEPTH);
  localparam int COUNT_BITS  = $clog2(READY_DEPTH + 1);
  localparam int SWITCH_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = (ID_BITS > PRIO_BITS) ? ID_BITS : PRIO_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_THREAD   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_PRIORITY = 1'd1;

  typedef enum logic [1:0] {
    OP_READY    = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_YIELD    = 2'd2,
    OP_NONE     = 2'd3
  } pts_op_t;

  typedef enum logic [1:0] {
    NS_READY    = 2'd0,
    NS_BLOCKED  = 2'd1,
    NS_ZOMBIE   = 2'd2,
    NS_RESERVED = 2'd3
  } pts_nstate_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READY,
    ST_REQUEUE,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } pts_state_t;

  typedef struct packed {
    pts_op_t               op;
    logic [ID_BITS-1:0]    thread_id;
    logic [PRIO_BITS-1:0]  priority_req;
    pts_nstate_t           thread_state;
  } pts_req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     running_thread;
    logic [PRIO_BITS-1:0]   running_priority;
    logic                   switched;
    logic                   reclaim_valid;
    logic [ID_BITS-1:0]     reclaim_thread;
    logic [SWITCH_BITS-1:0] switch_count;
    logic [COUNT_BITS-1:0]  ready_count;
    logic                   status;
  } pts_res_t;

  typedef struct packed {
    logic latch;
    logic do_ready;
    logic do_requeue;
    logic scan_init;
    logic scan_step;
    logic do_pick;
  } pts_cmd_t;

  typedef struct packed {
    logic scan_done;
  } pts_stat_t;

endpackage

// ----- src/priority_thread_scheduler_top.sv -----
// top level of the preemptive priority thread scheduler
//
// one request at a time: start is taken when busy is low, and one result
// appears on res for a single cycle with done high; the receiver cannot stall,
// so it must take res whenever done is high. a ready request passes through
// the ready and done states, a request with op code three goes straight to
// done, schedule passes the requeue, scan, pick and done states and yield the
// scan, pick and done states; the scan walks the ready-table entries present
// at scan time (at most 16) one slot per cycle to find the oldest entry of
// highest priority (for yield, only above the running priority). busy stays
// high through the done cycle.
// the idle thread id and priority are written on the cfg port; the user must
// do so only while idle (unenforced); writes never change the running thread.
module priority_thread_scheduler_top
  import pts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     start,
  input  pts_req_t                 req,
  output logic                     busy,
  // result channel
  output logic                     done,
  output pts_res_t                 res,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  pts_cmd_t  cmd;
  pts_stat_t stat;

  // sequencing of the request: capture, table update, scan, pick, report
  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (req.op),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // running thread, ready table, scan and counters
  pts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .res       (res)
  );

endmodule

// ----- src/pts_ctrl.sv -----
// controller state machine of the priority thread scheduler
module pts_ctrl
  import pts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pts_op_t   op,
  input  pts_stat_t stat,
  output logic      busy,
  output logic      done,
  output pts_cmd_t  cmd
);

  pts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_READY:    state_next = ST_READY;
            OP_SCHEDULE: state_next = ST_REQUEUE;
            OP_YIELD:    state_next = ST_SCAN;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_READY:   state_next = ST_DONE;
      ST_REQUEUE: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK:    state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.latch     = start;
        cmd.scan_init = start && (op == OP_YIELD);
      end
      ST_READY:   cmd.do_ready = 1'b1;
      ST_REQUEUE: begin
        cmd.do_requeue = 1'b1;
        cmd.scan_init  = 1'b1;
      end
      ST_SCAN:    cmd.scan_step = !stat.scan_done;
      ST_PICK:    cmd.do_pick = 1'b1;
      ST_DONE:    done = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

// ----- src/pts_datapath.sv -----
// ready table, running thread registers and scan datapath
module pts_datapath
  import pts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  pts_req_t                 req,
  input  pts_cmd_t                 cmd,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output pts_stat_t                stat,
  output pts_res_t                 res
);

  // configuration
  logic [ID_BITS-1:0]   idle_thread;
  logic [PRIO_BITS-1:0] idle_priority;

  // captured request
  pts_req_t req_q;

  // running thread and counters
  logic [ID_BITS-1:0]     run_id;
  logic [PRIO_BITS-1:0]   run_prio;
  logic [SWITCH_BITS-1:0] switches;
  logic [COUNT_BITS-1:0]  fill;
  logic                   switched;
  logic                   reclaim_valid;
  logic [ID_BITS-1:0]     reclaim_thread;
  logic                   status;

  // ready table, kept packed in append order
  logic [ID_BITS-1:0]   slot_id   [READY_DEPTH];
  logic [PRIO_BITS-1:0] slot_prio [READY_DEPTH];
  logic [ID_BITS-1:0]   shift_id  [READY_DEPTH];
  logic [PRIO_BITS-1:0] shift_prio[READY_DEPTH];

  // scan state
  logic [COUNT_BITS-1:0] scan_idx;
  logic                  best_valid;
  logic [SLOT_BITS-1:0]  best_idx;
  logic [ID_BITS-1:0]    best_id;
  logic [PRIO_BITS-1:0]  best_prio;
  logic                  scan_any;

  // table update controls
  logic                  remove_en;
  logic                  append_en;
  logic                  append_ok;
  logic [ID_BITS-1:0]    append_id;
  logic [PRIO_BITS-1:0]  append_prio;
  logic [COUNT_BITS-1:0] fill_rm;
  logic [COUNT_BITS-1:0] fill_next;

  logic                  is_idle;
  logic                  preempt;
  logic [ID_BITS-1:0]    scan_id;
  logic [PRIO_BITS-1:0]  scan_prio;
  logic                  scan_take;
  logic [ID_BITS-1:0]    pick_id;
  logic [PRIO_BITS-1:0]  pick_prio;
  logic                  pick_switch;

  assign is_idle = (run_id == idle_thread);
  assign preempt = (run_prio < req_q.priority_req);

  assign scan_id   = slot_id[scan_idx[SLOT_BITS-1:0]];
  assign scan_prio = slot_prio[scan_idx[SLOT_BITS-1:0]];
  assign scan_take = (scan_any && !best_valid) || (scan_prio > best_prio);
  assign stat.scan_done = (scan_idx == fill);

  // schedule falls back to the idle thread when nothing is ready
  assign pick_id     = best_valid ? best_id : idle_thread;
  assign pick_prio   = best_valid ? best_prio : idle_priority;
  assign pick_switch = (pick_id != run_id);

  always_comb begin
    remove_en   = 1'b0;
    append_en   = 1'b0;
    append_id   = run_id;
    append_prio = run_prio;
    if (cmd.do_ready) begin
      append_en = preempt ? !is_idle : 1'b1;
      if (!preempt) begin
        append_id   = req_q.thread_id;
        append_prio = req_q.priority_req;
      end
    end else if (cmd.do_requeue) begin
      append_en = (req_q.thread_state == NS_READY) && !is_idle;
    end else if (cmd.do_pick) begin
      remove_en = best_valid;
      append_en = (req_q.op == OP_YIELD) && best_valid && !is_idle;
    end
  end

  // removal happens before the append, so a yield never overflows
  assign fill_rm   = fill - COUNT_BITS'(remove_en);
  assign append_ok = append_en && (fill_rm != COUNT_BITS'(READY_DEPTH));
  assign fill_next = fill_rm + COUNT_BITS'(append_ok);

  always_comb begin
    for (int i = 0; i < READY_DEPTH - 1; i++) begin
      shift_id[i]   = slot_id[i + 1];
      shift_prio[i] = slot_prio[i + 1];
    end
    shift_id[READY_DEPTH-1]   = slot_id[READY_DEPTH-1];
    shift_prio[READY_DEPTH-1] = slot_prio[READY_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < READY_DEPTH; i++) begin
      if (append_ok && (COUNT_BITS'(i) == fill_rm)) begin
        slot_id[i]   <= append_id;
        slot_prio[i] <= append_prio;
      end else if (remove_en && (SLOT_BITS'(i) >= best_idx)) begin
        slot_id[i]   <= shift_id[i];
        slot_prio[i] <= shift_prio[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
  end

  // scan over the table, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_idx   <= '0;
      best_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + COUNT_BITS'(1);
      if (scan_take) begin
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_prio <= run_prio;
      scan_any  <= !(cmd.latch && (req.op == OP_YIELD));
    end else if (cmd.scan_step && scan_take) begin
      best_prio <= scan_prio;
      best_id   <= scan_id;
      best_idx  <= scan_idx[SLOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_thread   <= '0;
      idle_priority <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDLE_THREAD:   idle_thread   <= cfg_data[ID_BITS-1:0];
        CFG_IDLE_PRIORITY: idle_priority <= cfg_data[PRIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_id         <= '0;
      run_prio       <= '0;
      switches       <= '0;
      fill           <= '0;
      switched       <= 1'b0;
      reclaim_valid  <= 1'b0;
      reclaim_thread <= '0;
      status         <= 1'b0;
    end else begin
      fill <= fill_next;
      if (cmd.latch) begin
        switched       <= 1'b0;
        reclaim_valid  <= 1'b0;
        reclaim_thread <= '0;
        status         <= 1'b0;
      end
      if (append_en && !append_ok) begin
        status <= 1'b1;
      end
      if (cmd.do_ready && preempt) begin
        run_id   <= req_q.thread_id;
        run_prio <= req_q.priority_req;
        switches <= switches + SWITCH_BITS'(1);
        switched <= (req_q.thread_id != run_id);
      end
      if (cmd.do_pick) begin
        if (req_q.op == OP_SCHEDULE) begin
          run_id   <= pick_id;
          run_prio <= pick_prio;
          switches <= switches + SWITCH_BITS'(1);
          switched <= pick_switch;
          if (pick_switch && (req_q.thread_state == NS_ZOMBIE)) begin
            reclaim_valid  <= 1'b1;
            reclaim_thread <= run_id;
          end
        end else if (best_valid) begin
          run_id   <= best_id;
          run_prio <= best_prio;
          switches <= switches + SWITCH_BITS'(1);
          switched <= (best_id != run_id);
        end
      end
    end
  end

  assign res.running_thread   = run_id;
  assign res.running_priority = run_prio;
  assign res.switched         = switched;
  assign res.reclaim_valid    = reclaim_valid;
  assign res.reclaim_thread   = reclaim_thread;
  assign res.switch_count     = switches;
  assign res.ready_count      = fill;
  assign res.status           = status;

endmodule
